// ----- sv/tlrs_pkg.sv -----
package tlrs_pkg;

   typedef logic [2:0] op_type;
   typedef logic [4:0] slot_type;
   typedef logic [2:0] csr_idx_type;
   typedef logic [4:0] step_idx_type;

   localparam op_type OP_SAMPLE = 3'd0;
   localparam op_type OP_DRIVE  = 3'd1;
   localparam op_type OP_ADD    = 3'd2;
   localparam op_type OP_SUB    = 3'd3;
   localparam op_type OP_MUL    = 3'd4;
   localparam op_type OP_DIV    = 3'd5;
   localparam op_type OP_COMMIT = 3'd6;

   // writable slots
   localparam slot_type SLOT_P    = 5'd0;
   localparam slot_type SLOT_T0   = 5'd1;
   localparam slot_type SLOT_T1   = 5'd2;
   localparam slot_type SLOT_T2   = 5'd3;
   localparam slot_type SLOT_X1   = 5'd4;
   localparam slot_type SLOT_X2   = 5'd5;
   localparam slot_type SLOT_X3   = 5'd6;
   localparam slot_type SLOT_Y1   = 5'd7;
   localparam slot_type SLOT_Y2   = 5'd8;
   localparam slot_type SLOT_Y3   = 5'd9;
   // read-only sources
   localparam slot_type SRC_TD    = 5'd10;
   localparam slot_type SRC_TF    = 5'd11;
   localparam slot_type SRC_SGN   = 5'd12;
   localparam slot_type SRC_GAIN  = 5'd13;
   localparam slot_type SRC_ONE   = 5'd14;
   localparam slot_type SRC_TWO   = 5'd15;
   localparam slot_type SRC_U0    = 5'd16;
   localparam slot_type SRC_U1    = 5'd17;
   localparam slot_type SRC_U2    = 5'd18;
   localparam slot_type SRC_H1    = 5'd19;
   localparam slot_type SRC_H2    = 5'd20;
   localparam slot_type SRC_H3N   = 5'd21;
   localparam slot_type SRC_H3O   = 5'd22;

   localparam csr_idx_type CSR_SAMPLE_PERIOD = 3'd0;
   localparam csr_idx_type CSR_FILTER_TIME   = 3'd1;
   localparam csr_idx_type CSR_LOOP_SIGN     = 3'd2;
   localparam csr_idx_type CSR_LOOP_GAIN     = 3'd3;
   localparam csr_idx_type CSR_INIT_ONE      = 3'd4;
   localparam csr_idx_type CSR_INIT_TWO      = 3'd5;
   localparam csr_idx_type CSR_INIT_THREE    = 3'd6;

   localparam step_idx_type PROG_LAST = 5'd29;

   typedef struct packed {
      op_type   op;
      slot_type dst;
      slot_type sa;
      slot_type sb;
   } step_type;

   typedef struct packed {
      logic     start;
      op_type   op;
      slot_type dst;
      slot_type sa;
      slot_type sb;
   } cmd_type;

   typedef struct packed {
      logic done;
   } sts_type;

   function automatic step_type prog_step(step_idx_type idx);
      step_type s;
      s = '0;
      case (idx)
         5'd0:  s = '{OP_MUL, SLOT_T0, SRC_SGN,  SRC_GAIN};
         5'd1:  s = '{OP_MUL, SLOT_P,  SLOT_T0,  SRC_TD};
         5'd2:  s = '{OP_SUB, SLOT_T0, SRC_ONE,  SLOT_P};
         5'd3:  s = '{OP_MUL, SLOT_T0, SRC_H1,   SLOT_T0};
         5'd4:  s = '{OP_ADD, SLOT_T0, SLOT_T0,  SRC_U2};
         5'd5:  s = '{OP_SUB, SLOT_X1, SLOT_T0,  SRC_U1};
         5'd6:  s = '{OP_SUB, SLOT_T0, SRC_TF,   SRC_TD};
         5'd7:  s = '{OP_SUB, SLOT_T0, SLOT_T0,  SLOT_P};
         5'd8:  s = '{OP_MUL, SLOT_T0, SRC_H2,   SLOT_T0};
         5'd9:  s = '{OP_SUB, SLOT_T1, SRC_TD,   SRC_TF};
         5'd10: s = '{OP_MUL, SLOT_T1, SRC_U1,   SLOT_T1};
         5'd11: s = '{OP_ADD, SLOT_T0, SLOT_T0,  SLOT_T1};
         5'd12: s = '{OP_DIV, SLOT_T0, SLOT_T0,  SRC_TF};
         5'd13: s = '{OP_ADD, SLOT_X2, SLOT_T0,  SRC_U2};
         5'd14: s = '{OP_MUL, SLOT_T0, SLOT_P,   SRC_TF};
         5'd15: s = '{OP_SUB, SLOT_T0, SRC_TWO,  SLOT_T0};
         5'd16: s = '{OP_MUL, SLOT_T0, SRC_H3N,  SLOT_T0};
         5'd17: s = '{OP_MUL, SLOT_T1, SLOT_P,   SRC_TD};
         5'd18: s = '{OP_ADD, SLOT_T1, SRC_ONE,  SLOT_T1};
         5'd19: s = '{OP_MUL, SLOT_T2, SLOT_P,   SRC_TF};
         5'd20: s = '{OP_SUB, SLOT_T1, SLOT_T1,  SLOT_T2};
         5'd21: s = '{OP_MUL, SLOT_T1, SRC_H3O,  SLOT_T1};
         5'd22: s = '{OP_SUB, SLOT_T0, SLOT_T0,  SLOT_T1};
         5'd23: s = '{OP_ADD, SLOT_T0, SLOT_T0,  SRC_U2};
         5'd24: s = '{OP_SUB, SLOT_T0, SLOT_T0,  SRC_U1};
         5'd25: s = '{OP_SUB, SLOT_T0, SLOT_T0,  SRC_U1};
         5'd26: s = '{OP_ADD, SLOT_X3, SLOT_T0,  SRC_U0};
         5'd27: s = '{OP_SUB, SLOT_Y1, SRC_U2,   SLOT_X1};
         5'd28: s = '{OP_SUB, SLOT_Y2, SRC_U2,   SLOT_X2};
         5'd29: s = '{OP_SUB, SLOT_Y3, SRC_U2,   SLOT_X3};
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ----- sv/tlrs_if.sv -----
interface tlrs_req_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sample_value;
   modport source (output valid, sample_value, input ready);
   modport sink (input valid, sample_value, output ready);
endinterface

interface tlrs_rsp_if #(parameter int DATA_WIDTH = 32);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] state_one;
   logic signed [DATA_WIDTH-1:0] error_one;
   logic signed [DATA_WIDTH-1:0] state_two;
   logic signed [DATA_WIDTH-1:0] error_two;
   logic signed [DATA_WIDTH-1:0] state_three;
   logic signed [DATA_WIDTH-1:0] error_three;
   logic                         saturated;
   modport source (output valid, state_one, error_one, state_two, error_two,
                   state_three, error_three, saturated, input ready);
   modport sink (input valid, state_one, error_one, state_two, error_two,
                 state_three, error_three, saturated, output ready);
endinterface

interface tlrs_csr_if #(parameter int DATA_WIDTH = 32);
   logic                        valid;
   logic                        ready;
   tlrs_pkg::csr_idx_type       index;
   logic [DATA_WIDTH-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/tlrs_datapath.sv -----
module tlrs_datapath #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tlrs_pkg::cmd_type     cmd,
   output tlrs_pkg::sts_type     sts,
   input  logic [W-1:0]          sample_value,
   input  logic                  csr_write,
   input  tlrs_pkg::csr_idx_type csr_index,
   input  logic [W-1:0]          csr_data,
   output logic [W-1:0]          out_x1,
   output logic [W-1:0]          out_y1,
   output logic [W-1:0]          out_x2,
   output logic [W-1:0]          out_y2,
   output logic [W-1:0]          out_x3,
   output logic [W-1:0]          out_y3,
   output logic                  out_sat
);
   import tlrs_pkg::*;

   localparam int DVW = W + F;
   localparam int CW  = $clog2(DVW + 1);
   localparam int FW  = (2 * W > DVW) ? 2 * W : DVW;
   localparam int RK  = (W % 2 == 0) ? W + 1 : W + 2;
   localparam logic [W+2:0] RECIP3 = ((W+3)'(1) << RK) / (W+3)'(3) + (W+3)'(1);
   localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] ONE_V = (F <= W - 2) ? (W'(1) << F) : VMAX;
   localparam logic [W-1:0] TWO_V = (F <= W - 3) ? (W'(2) << F) : VMAX;
   localparam logic CONST_CLIP = (F > W - 3);

   // configuration
   logic [W-2:0] td_ff, tf_ff;
   logic [W-1:0] sgn_ff, gain_ff;
   // item state
   logic [W-1:0] win0_ff, win1_ff, win2_ff;
   logic [W-1:0] u0_ff, u1_ff, u2_ff;
   logic [W-1:0] h1_ff, h2_ff, h3n_ff, h3o_ff;
   logic         clip_ff;
   // working slots
   logic [W-1:0] p_ff, t0_ff, t1_ff, t2_ff, x1_ff, x2_ff, x3_ff, y1_ff, y2_ff, y3_ff;
   // multi-cycle unit
   logic           busy_ff;
   logic [CW-1:0]  cnt_ff;
   op_type         op_ff;
   slot_type       dst_ff;
   logic           neg_ff, dz_ff;
   logic [2*W-1:0] mag_ff;
   logic [DVW-1:0] quo_ff;
   logic [W-1:0]   rem_ff, dvs_ff;

   logic [W-1:0]   a_val, b_val;
   logic [W:0]     asum;
   logic           as_ovf;
   logic [W-1:0]   as_val;
   logic [W-1:0]   ma, mb, sa0, sa1, sb1, sb2, s0, s1, s2;
   logic [W:0]     spread;
   logic [W-1:0]   drv_r, drv_q;
   logic [1:0]     drv_rem;
   logic [DVW-1:0] drv_frac, drv_u;
   logic [W:0]     rem_sh;
   logic           rem_ge;
   logic           finish;
   logic [FW-1:0]  fit_mag, fit_lim;
   logic           fit_ovf;
   logic [W-1:0]   fit_val;
   logic           start_single;

   function automatic logic [W-1:0] src_val(slot_type c);
      logic [W-1:0] v;
      v = '0;
      case (c)
         SLOT_P:   v = p_ff;
         SLOT_T0:  v = t0_ff;
         SLOT_T1:  v = t1_ff;
         SLOT_T2:  v = t2_ff;
         SLOT_X1:  v = x1_ff;
         SLOT_X2:  v = x2_ff;
         SLOT_X3:  v = x3_ff;
         SLOT_Y1:  v = y1_ff;
         SLOT_Y2:  v = y2_ff;
         SLOT_Y3:  v = y3_ff;
         SRC_TD:   v = {1'b0, td_ff};
         SRC_TF:   v = {1'b0, tf_ff};
         SRC_SGN:  v = sgn_ff;
         SRC_GAIN: v = gain_ff;
         SRC_ONE:  v = ONE_V;
         SRC_TWO:  v = TWO_V;
         SRC_U0:   v = u0_ff;
         SRC_U1:   v = u1_ff;
         SRC_U2:   v = u2_ff;
         SRC_H1:   v = h1_ff;
         SRC_H2:   v = h2_ff;
         SRC_H3N:  v = h3n_ff;
         SRC_H3O:  v = h3o_ff;
         default:  v = '0;
      endcase
      return v;
   endfunction

   always_comb begin
      a_val  = src_val(cmd.sa);
      b_val  = src_val(cmd.sb);
      asum   = (cmd.op == OP_SUB) ? ({a_val[W-1], a_val} - {b_val[W-1], b_val})
                                  : ({a_val[W-1], a_val} + {b_val[W-1], b_val});
      as_ovf = asum[W] ^ asum[W-1];
      as_val = as_ovf ? (asum[W] ? VMIN : VMAX) : asum[W-1:0];
      ma     = a_val[W-1] ? (~a_val + W'(1)) : a_val;
      mb     = b_val[W-1] ? (~b_val + W'(1)) : b_val;
   end

   // window shift and three compare-swaps
   always_comb begin
      sa0 = win1_ff;
      sa1 = win2_ff;
      if ($signed(sa0) > $signed(sa1)) begin
         sa0 = win2_ff;
         sa1 = win1_ff;
      end
      sb1 = sa1;
      sb2 = sample_value;
      if ($signed(sb1) > $signed(sb2)) begin
         sb1 = sample_value;
         sb2 = sa1;
      end
      s0 = sa0;
      s1 = sb1;
      if ($signed(s0) > $signed(s1)) begin
         s0 = sb1;
         s1 = sa0;
      end
      s2 = sb2;
   end

   // drive term: r/3 by reciprocal product, then 20*q plus the remainder share
   always_comb begin
      spread  = {win2_ff[W-1], win2_ff} - {win0_ff[W-1], win0_ff};
      drv_r   = spread[W:1];
      drv_q   = W'(mag_ff >> RK);
      drv_rem = 2'(drv_r - (drv_q + (drv_q << 1)));
      case (drv_rem)
         2'd0:    drv_frac = DVW'(0);
         2'd1:    drv_frac = DVW'(6);
         default: drv_frac = DVW'(13);
      endcase
      drv_u   = (DVW'(drv_q) << 4) + (DVW'(drv_q) << 2) + drv_frac;
      rem_sh  = {rem_ff, quo_ff[DVW-1]};
      rem_ge  = rem_sh >= {1'b0, dvs_ff};
   end

   always_comb begin
      finish  = busy_ff && (cnt_ff == '0);
      fit_mag = (op_ff == OP_MUL) ? FW'(mag_ff >> F) : FW'(quo_ff);
      fit_lim = neg_ff ? (FW'(VMAX) + FW'(1)) : FW'(VMAX);
      fit_ovf = dz_ff || (fit_mag > fit_lim);
      fit_val = fit_ovf ? (neg_ff ? VMIN : VMAX)
                        : (neg_ff ? (~fit_mag[W-1:0] + W'(1)) : fit_mag[W-1:0]);
      start_single = cmd.start && (cmd.op == OP_SAMPLE || cmd.op == OP_ADD ||
                                   cmd.op == OP_SUB || cmd.op == OP_COMMIT);
      sts.done = start_single || finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         td_ff    <= (W-1)'(655);
         tf_ff    <= (W-1)'(19661);
         sgn_ff   <= W'(65536);
         gain_ff  <= W'(1310720);
         win0_ff  <= '0;
         win1_ff  <= '0;
         win2_ff  <= '0;
         u0_ff    <= '0;
         u1_ff    <= '0;
         u2_ff    <= '0;
         h1_ff    <= W'(65536);
         h2_ff    <= W'(65536);
         h3n_ff   <= W'(65536);
         h3o_ff   <= W'(65536);
         clip_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_SAMPLE_PERIOD: td_ff <= csr_data[W-2:0];
               CSR_FILTER_TIME:   tf_ff <= csr_data[W-2:0];
               CSR_LOOP_SIGN:     sgn_ff <= csr_data;
               CSR_LOOP_GAIN:     gain_ff <= csr_data;
               CSR_INIT_ONE: begin
                  h1_ff    <= csr_data;
               end
               CSR_INIT_TWO: begin
                  h2_ff    <= csr_data;
               end
               CSR_INIT_THREE: begin
                  h3n_ff   <= csr_data;
                  h3o_ff   <= csr_data;
               end
               default: ;
            endcase
         end
         if (cmd.start) begin
            case (cmd.op) inside
               OP_SAMPLE: begin
                  win0_ff <= s0;
                  win1_ff <= s1;
                  win2_ff <= s2;
                  clip_ff <= 1'b0;
               end
               OP_ADD, OP_SUB: clip_ff <= clip_ff | as_ovf;
               OP_MUL: begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= '0;
               end
               OP_DRIVE: begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= CW'(1);
               end
               OP_DIV: begin
                  busy_ff <= 1'b1;
                  cnt_ff  <= (tf_ff == '0) ? '0 : CW'(DVW);
               end
               OP_COMMIT: begin
                  h1_ff  <= x1_ff;
                  h2_ff  <= x2_ff;
                  h3o_ff <= h3n_ff;
                  h3n_ff <= x3_ff;
                  u0_ff  <= u1_ff;
                  u1_ff  <= u2_ff;
               end
               default: ;
            endcase
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - CW'(1);
            end else begin
               busy_ff <= 1'b0;
               clip_ff <= clip_ff | fit_ovf;
               if (op_ff == OP_DRIVE) begin
                  case (dst_ff[1:0])
                     2'd0:    u0_ff <= fit_val;
                     2'd1:    u1_ff <= fit_val;
                     default: u2_ff <= fit_val;
                  endcase
               end
            end
         end
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         op_ff  <= cmd.op;
         dst_ff <= cmd.dst;
         case (cmd.op)
            OP_MUL: begin
               mag_ff <= (2*W)'(ma) * (2*W)'(mb);
               neg_ff <= a_val[W-1] ^ b_val[W-1];
               dz_ff  <= 1'b0;
            end
            OP_DRIVE: begin
               mag_ff <= (2*W)'(drv_r) * (2*W)'(RECIP3);
               neg_ff <= 1'b0;
               dz_ff  <= 1'b0;
            end
            OP_DIV: begin
               quo_ff <= DVW'(ma) << F;
               rem_ff <= '0;
               dvs_ff <= {1'b0, tf_ff};
               neg_ff <= a_val[W-1];
               dz_ff  <= (tf_ff == '0);
            end
            default: ;
         endcase
      end else if (busy_ff && cnt_ff != '0) begin
         if (op_ff == OP_DRIVE) begin
            quo_ff <= drv_u;
         end else begin
            rem_ff <= rem_ge ? W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[W-1:0];
            quo_ff <= {quo_ff[DVW-2:0], rem_ge};
         end
      end
   end

   // slot write-back
   slot_type     wb_dst;
   logic [W-1:0] wb_val;
   logic         wb_en;

   always_comb begin
      wb_en  = 1'b0;
      wb_dst = cmd.dst;
      wb_val = as_val;
      if (cmd.start && (cmd.op == OP_ADD || cmd.op == OP_SUB)) begin
         wb_en = 1'b1;
      end else if (finish && (op_ff == OP_MUL || op_ff == OP_DIV)) begin
         wb_en  = 1'b1;
         wb_dst = dst_ff;
         wb_val = fit_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_en) begin
         case (wb_dst)
            SLOT_P:  p_ff  <= wb_val;
            SLOT_T0: t0_ff <= wb_val;
            SLOT_T1: t1_ff <= wb_val;
            SLOT_T2: t2_ff <= wb_val;
            SLOT_X1: x1_ff <= wb_val;
            SLOT_X2: x2_ff <= wb_val;
            SLOT_X3: x3_ff <= wb_val;
            SLOT_Y1: y1_ff <= wb_val;
            SLOT_Y2: y2_ff <= wb_val;
            SLOT_Y3: y3_ff <= wb_val;
            default: ;
         endcase
      end
      if (cmd.start && cmd.op == OP_COMMIT) begin
         out_x1  <= x1_ff;
         out_y1  <= y1_ff;
         out_x2  <= x2_ff;
         out_y2  <= y2_ff;
         out_x3  <= x3_ff;
         out_y3  <= y3_ff;
         out_sat <= clip_ff | CONST_CLIP;
      end
   end

endmodule

// ----- sv/tlrs_ctrl.sv -----
module tlrs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlrs_pkg::cmd_type cmd,
   input  tlrs_pkg::sts_type sts
);
   import tlrs_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DRV  = 3'd1;
   localparam logic [2:0] S_DRVW = 3'd2;
   localparam logic [2:0] S_RUN  = 3'd3;
   localparam logic [2:0] S_RUNW = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]   state_ff, state_in;
   logic [1:0]   seen_ff, seen_in;
   logic [1:0]   dcnt_ff, dcnt_in;
   step_idx_type step_ff, step_in;
   logic         rsp_valid_ff, rsp_valid_in;
   step_type     cur;
   slot_type     drv_dst;

   always_comb begin
      cur          = prog_step(step_ff);
      drv_dst      = (dcnt_ff == 2'd2) ? 5'd2 : {3'b000, dcnt_ff};
      state_in     = state_ff;
      seen_in      = seen_ff;
      dcnt_in      = dcnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff) inside
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.op    = OP_SAMPLE;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (seen_ff != 2'd3) begin
                  seen_in = seen_ff + 2'd1;
               end else begin
                  state_in = S_DRV;
               end
            end
         end
         S_DRV, S_DRVW: begin
            cmd.op    = OP_DRIVE;
            cmd.dst   = drv_dst;
            cmd.start = (state_ff == S_DRV);
            if (state_ff == S_DRV) begin
               state_in = S_DRVW;
            end else if (sts.done) begin
               if (dcnt_ff != 2'd2) begin
                  dcnt_in  = dcnt_ff + 2'd1;
                  state_in = S_IDLE;
               end else begin
                  step_in  = '0;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN, S_RUNW: begin
            cmd.op    = cur.op;
            cmd.dst   = cur.dst;
            cmd.sa    = cur.sa;
            cmd.sb    = cur.sb;
            cmd.start = (state_ff == S_RUN);
            if (sts.done) begin
               if (step_ff == PROG_LAST) begin
                  state_in = S_OUT;
               end else begin
                  step_in  = step_ff + 5'd1;
                  state_in = S_RUN;
               end
            end else begin
               state_in = S_RUNW;
            end
         end
         S_OUT: begin
            cmd.op = OP_COMMIT;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.start    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seen_ff      <= '0;
         dcnt_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         dcnt_ff      <= dcnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/three_loop_discrete_response_sim_top.sv -----
// three-loop discrete response simulator
// req_ch: one measured sample per transfer; csr_ch: register writes, always
// ready, to be used only while the block is idle; rsp_ch: one result per
// sample once warm-up is over (state and error of the three loops, plus a
// saturation flag).
// the first three samples give no result; the next two compute the drive
// term only.
// every later sample runs the drive term and then the step program: the
// bit-serial divider runs once, for the loop-two quotient, and the drive
// term and each product use the multi-cycle unit as well.
// one sample is worked on at a time; the next transfer is taken as soon as
// the current one has moved its result into the output register.
// a result waits in that register while the receiver stalls; the block
// computes the following sample meanwhile and holds it until the register
// frees.
// reset loads the register defaults, clears the sample window and drive
// history and sets each loop history to its initial state.
module three_loop_discrete_response_sim_top #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input logic        clock,
   input logic        reset,
   tlrs_req_if.sink   req_ch,
   tlrs_rsp_if.source rsp_ch,
   tlrs_csr_if.sink   csr_ch
);
   import tlrs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ch.ready = 1'b1;

   tlrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   tlrs_datapath #(
      .W (DATA_WIDTH),
      .F (FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .sample_value (req_ch.sample_value),
      .csr_write    (csr_ch.valid),
      .csr_index    (csr_ch.index),
      .csr_data     (csr_ch.data),
      .out_x1       (rsp_ch.state_one),
      .out_y1       (rsp_ch.error_one),
      .out_x2       (rsp_ch.state_two),
      .out_y2       (rsp_ch.error_two),
      .out_x3       (rsp_ch.state_three),
      .out_y3       (rsp_ch.error_three),
      .out_sat      (rsp_ch.saturated)
   );

`ifndef NO_ASSERTIONS
   a_idle_only_sample: assert property (@(posedge clock) disable iff (reset)
      req_ch.ready |-> (!cmd.start || cmd.op == OP_SAMPLE))
      else $error("command other than sample issued while idle");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && cmd.op == OP_COMMIT) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("result overwritten before transfer");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      (cmd.start && cmd.op == OP_COMMIT) |=> rsp_ch.valid)
      else $error("commit without result");
`endif

endmodule
